@@ rtl/cht_pkg.sv @@
// cht_pkg: shared types and codes for the chained hash table.
// Used by chained_hash_table and cht_mod; depends on nothing.
`default_nettype none
package cht_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  localparam logic CFG_BUCKET_COUNT = 1'b0;
  localparam logic CFG_ABSENT_VALUE = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [30:0]        key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [30:0] key;
  } div_req_t;

endpackage
`default_nettype wire

@@ rtl/chained_hash_table.sv @@
// chained_hash_table: key-value store, separate chaining over a fixed entry pool.
// Depends on cht_pkg, cht_mod and cht_ram.
//
// One command at a time: start is taken while busy is low, the result appears
// on out_valid for one cycle and cannot be stalled. After reset busy stays high
// while the bucket heads are cleared. A command then holds busy through the
// serial key-mod-bucket_count remainder, the bucket head read, one read and
// one compare per chain entry, and at the end of the chain taking a pool
// entry, the updates and the result. out_valid is high in the same cycle in
// which busy falls.
`default_nettype none
module chained_hash_table #(
  parameter int MAX_BUCKETS  = 256,
  parameter int POOL_ENTRIES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire cht_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output cht_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);
  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = AW + 1;
  localparam int BA = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int BW = $clog2(MAX_BUCKETS + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
  localparam int EW = 31 + 32 + LW;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_HASH = 4'd2, S_HEAD = 4'd3,
    S_HEADW = 4'd4, S_RD = 4'd5, S_CMP = 4'd6, S_TAKE = 4'd7, S_FRW = 4'd8,
    S_INS = 4'd9, S_UNL = 4'd10, S_REL = 4'd11, S_OUT = 4'd12;

  logic [3:0]    st_r, st_nxt;
  logic [8:0]    bcnt_r;
  logic [31:0]   absent_r;
  cht_pkg::in_item_t item_r, item_nxt;
  logic [BA-1:0] bkt_r, bkt_nxt, clr_r, clr_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, hd_r, hd_nxt, link_r, link_nxt;
  logic [LW-1:0] free_r, free_nxt, fresh_r, fresh_nxt;
  logic [AW-1:0] newe_r, newe_nxt;
  logic [62:0]   pword_r, pword_nxt;  // key and value of the previous entry
  cht_pkg::out_item_t res_r, res_nxt;
  logic          outv_r, outv_nxt;

  // entry memory: {key, value, link}
  logic          ewe;
  logic [AW-1:0] eaddr;
  logic [EW-1:0] ewdata, erdata;
  logic [30:0]   e_key;
  logic [31:0]   e_val;
  logic [LW-1:0] e_link;
  assign e_key  = erdata[EW-1 -: 31];
  assign e_val  = erdata[LW +: 32];
  assign e_link = erdata[LW-1:0];

  cht_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_ram (
    .clk(clk), .we(ewe), .addr(eaddr), .wdata(ewdata), .rdata(erdata));

  // bucket head memory
  logic          hwe;
  logic [BA-1:0] haddr;
  logic [LW-1:0] hwdata, hrdata;

  cht_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_head (
    .clk(clk), .we(hwe), .addr(haddr), .wdata(hwdata), .rdata(hrdata));

  logic [BW-1:0] divisor;
  always_comb begin
    if (bcnt_r == 9'd0) divisor = BW'(1);
    else if ({23'd0, bcnt_r} > MAX_BUCKETS) divisor = BW'(MAX_BUCKETS);
    else divisor = BW'(bcnt_r);
  end

  cht_pkg::div_req_t dreq;
  logic          ddone;
  logic [BW-1:0] drem;
  assign dreq.start = (st_r == S_IDLE) && start;
  assign dreq.key   = in_item.key;
  cht_mod #(.BW(BW)) u_mod (.clk(clk), .rst_n(rst_n), .req(dreq),
    .divisor(divisor), .done(ddone), .rem(drem));

  always_comb begin
    st_nxt = st_r; item_nxt = item_r; bkt_nxt = bkt_r; clr_nxt = clr_r;
    cur_nxt = cur_r; prev_nxt = prev_r; hd_nxt = hd_r; link_nxt = link_r;
    free_nxt = free_r; fresh_nxt = fresh_r; newe_nxt = newe_r; pword_nxt = pword_r;
    res_nxt = res_r; outv_nxt = 1'b0;
    ewe = 1'b0; eaddr = cur_r[AW-1:0]; ewdata = erdata;
    hwe = 1'b0; haddr = bkt_r; hwdata = NIL;
    unique case (st_r)
      S_CLR: begin
        hwe = 1'b1; haddr = clr_r; clr_nxt = clr_r + BA'(1);
        if (clr_r == BA'(MAX_BUCKETS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item; st_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (ddone) begin
          bkt_nxt = BA'(drem); st_nxt = S_HEAD;
        end
      end
      S_HEAD: st_nxt = S_HEADW;
      S_HEADW: begin
        hd_nxt = hrdata; cur_nxt = hrdata; prev_nxt = NIL; st_nxt = S_RD;
      end
      S_RD: begin
        if (cur_r >= NIL) begin
          res_nxt.status = cht_pkg::ST_OK; res_nxt.found_value = 32'd0;
          st_nxt = S_OUT;
          unique case (item_r.command)
            cht_pkg::CMD_INSERT: st_nxt = S_TAKE;
            cht_pkg::CMD_REMOVE: res_nxt.status = cht_pkg::ST_ABSENT;
            cht_pkg::CMD_FIND: begin
              res_nxt.status = cht_pkg::ST_ABSENT; res_nxt.found_value = absent_r;
            end
            default: ;
          endcase
        end else st_nxt = S_CMP;
      end
      S_CMP: begin
        if (e_key == item_r.key) begin
          res_nxt.status = cht_pkg::ST_OK; res_nxt.found_value = 32'd0;
          st_nxt = S_OUT;
          unique case (item_r.command)
            cht_pkg::CMD_INSERT: res_nxt.status = cht_pkg::ST_DUP;
            cht_pkg::CMD_REMOVE: begin
              link_nxt = e_link; st_nxt = S_UNL;
            end
            cht_pkg::CMD_FIND: res_nxt.found_value = e_val;
            default: ;
          endcase
        end else begin
          prev_nxt = cur_r; pword_nxt = erdata[EW-1:LW]; cur_nxt = e_link;
          st_nxt = S_RD;
        end
      end
      S_TAKE: begin
        priority if (free_r < NIL) begin
          eaddr = free_r[AW-1:0]; newe_nxt = free_r[AW-1:0]; st_nxt = S_FRW;
        end else if (fresh_r < NIL) begin
          newe_nxt = fresh_r[AW-1:0]; fresh_nxt = fresh_r + LW'(1); st_nxt = S_INS;
        end else begin
          res_nxt.status = cht_pkg::ST_FULL; res_nxt.found_value = 32'd0;
          st_nxt = S_OUT;
        end
      end
      S_FRW: begin
        free_nxt = e_link; st_nxt = S_INS;
      end
      S_INS: begin
        ewe = 1'b1; eaddr = newe_r; ewdata = {item_r.key, item_r.value, hd_r};
        hwe = 1'b1; hwdata = {1'b0, newe_r};
        res_nxt.status = cht_pkg::ST_OK; res_nxt.found_value = 32'd0;
        st_nxt = S_OUT;
      end
      S_UNL: begin
        if (prev_r < NIL) begin
          ewe = 1'b1; eaddr = prev_r[AW-1:0]; ewdata = {pword_r, link_r};
        end else begin
          hwe = 1'b1; hwdata = link_r;
        end
        st_nxt = S_REL;
      end
      S_REL: begin
        ewe = 1'b1; eaddr = cur_r[AW-1:0]; ewdata = {item_r.key, 32'd0, free_r};
        free_nxt = cur_r;
        res_nxt.status = cht_pkg::ST_OK; res_nxt.found_value = 32'd0;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        outv_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; bcnt_r <= 9'd64; absent_r <= '1;
      free_r <= NIL; fresh_r <= '0; outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; free_r <= free_nxt; fresh_r <= fresh_nxt;
      outv_r <= outv_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cht_pkg::CFG_BUCKET_COUNT) bcnt_r <= cfg_data[8:0];
        else absent_r <= cfg_data;
      end
    end
    item_r <= item_nxt; bkt_r <= bkt_nxt; cur_r <= cur_nxt; prev_r <= prev_nxt;
    hd_r <= hd_nxt; link_r <= link_nxt; newe_r <= newe_nxt; pword_r <= pword_nxt;
    res_r <= res_nxt;
  end

  assign busy      = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE) && !start;
  assign out_valid = outv_r;
  assign out_item  = res_r;

  property p_out_after_out_state;
    @(posedge clk) disable iff (!rst_n) out_valid |-> $past(st_r) == S_OUT;
  endproperty
  a_out: assert property (p_out_after_out_state) else $error("stray result");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NIL) else $error("pool count overflow");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= NIL) else $error("free list head out of range");
endmodule
`default_nettype wire

@@ rtl/cht_ram.sv @@
// cht_ram: generic single-port RAM with registered read.
// Standalone; no dependencies.
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/cht_mod.sv @@
// cht_mod: bit-serial remainder of a 31-bit key by the bucket count.
// Depends on cht_pkg.
`default_nettype none
module cht_mod #(
  parameter int BW = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cht_pkg::div_req_t req,
  input  wire logic [BW-1:0]    divisor,
  output logic                  done,
  output logic [BW-1:0]         rem
);
  logic [30:0] sh_r, sh_nxt;
  logic [BW:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [BW:0] trial;

  always_comb begin
    sh_nxt  = sh_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial   = {rem_r[BW-1:0], sh_r[30]};
    if (req.start) begin
      sh_nxt  = req.key;
      rem_nxt = '0;
      cnt_nxt = 5'd0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      sh_nxt  = {sh_r[29:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd30) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = run_r && (cnt_r == 5'd30);
  assign rem  = rem_nxt[BW-1:0];
endmodule
`default_nettype wire
